// ===== hw/rtl/encoder_volume_mute_channel_macros.svh =====
// Assertion helpers used by encoder_volume_mute_channel.sv.
`ifndef ENCODER_VOLUME_MUTE_CHANNEL_MACROS_SVH
`define ENCODER_VOLUME_MUTE_CHANNEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("evm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("evm assertion failed");

`endif

// ===== hw/rtl/evm_pkg.sv =====
package evm_pkg;

  localparam int unsigned CodeW    = 2;
  localparam int unsigned StepW    = 7;
  localparam int unsigned VolW     = 8;
  localparam int unsigned HoldoffW = 24;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LevelW   = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [StepW-1:0]    StepReset    = 7'd3;
  localparam logic [VolW-1:0]     MinVolReset  = 8'd0;
  localparam logic [VolW-1:0]     MaxVolReset  = 8'd100;
  localparam logic [HoldoffW-1:0] HoldoffReset = 24'd10000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_SIZE  = 2'd0,
    CFG_MIN_VOLUME = 2'd1,
    CFG_MAX_VOLUME = 2'd2,
    CFG_HOLDOFF_US = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_CCW  = 2'd1,
    MOVE_CW   = 2'd2,
    MOVE_BAD  = 2'd3
  } move_e;

  typedef struct packed {
    logic [StepW-1:0]    step_size;
    logic [VolW-1:0]     min_volume;
    logic [VolW-1:0]     max_volume;
    logic [HoldoffW-1:0] holdoff_us;
  } cfg_t;

  // Quadrature transition table, indexed by previous code and new code.
  function automatic move_e quad_move(input logic [CodeW-1:0] prev,
                                      input logic [CodeW-1:0] code);
    move_e m;
    m = MOVE_NONE;
    case ({prev, code})
      4'b0000: m = MOVE_NONE;
      4'b0001: m = MOVE_CW;
      4'b0010: m = MOVE_CCW;
      4'b0011: m = MOVE_BAD;
      4'b0100: m = MOVE_CCW;
      4'b0101: m = MOVE_NONE;
      4'b0110: m = MOVE_BAD;
      4'b0111: m = MOVE_CW;
      4'b1000: m = MOVE_CW;
      4'b1001: m = MOVE_BAD;
      4'b1010: m = MOVE_NONE;
      4'b1011: m = MOVE_CCW;
      4'b1100: m = MOVE_BAD;
      4'b1101: m = MOVE_CCW;
      4'b1110: m = MOVE_CW;
      4'b1111: m = MOVE_NONE;
      default: m = MOVE_NONE;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/evm_if.sv =====
interface evm_in_if;
  logic                          valid;
  logic                          ready;
  logic [evm_pkg::CodeW-1:0]     encoder_code;
  logic                          mute_switch;
  logic                          volume_switch;
  logic [evm_pkg::TimeW-1:0]     time_us;

  modport source (output valid, encoder_code, mute_switch, volume_switch, time_us,
                  input ready);
  modport sink (input valid, encoder_code, mute_switch, volume_switch, time_us,
                output ready);
endinterface

interface evm_out_if;
  logic                          valid;
  logic                          ready;
  logic [evm_pkg::VolW-1:0]      volume;
  logic                          volume_report;
  logic                          muted;
  logic                          mute_report;
  logic                          backlight_on;

  modport source (output valid, volume, volume_report, muted, mute_report, backlight_on,
                  input ready);
  modport sink (input valid, volume, volume_report, muted, mute_report, backlight_on,
                output ready);
endinterface

// ===== hw/rtl/evm_cfg.sv =====
module evm_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [evm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [evm_pkg::CfgDataW-1:0]    cfg_data_i,
  output evm_pkg::cfg_t                   cfg_o
);

  evm_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (evm_pkg::cfg_idx_e'(cfg_idx_i))
        evm_pkg::CFG_STEP_SIZE:  cfg_d.step_size  = cfg_data_i[evm_pkg::StepW-1:0];
        evm_pkg::CFG_MIN_VOLUME: cfg_d.min_volume = cfg_data_i[evm_pkg::VolW-1:0];
        evm_pkg::CFG_MAX_VOLUME: cfg_d.max_volume = cfg_data_i[evm_pkg::VolW-1:0];
        evm_pkg::CFG_HOLDOFF_US: cfg_d.holdoff_us = cfg_data_i[evm_pkg::HoldoffW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size  <= evm_pkg::StepReset;
      cfg_q.min_volume <= evm_pkg::MinVolReset;
      cfg_q.max_volume <= evm_pkg::MaxVolReset;
      cfg_q.holdoff_us <= evm_pkg::HoldoffReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/encoder_volume_mute_channel.sv =====
// Channel   Dir  Fields
// in_ch     in   encoder_code, mute_switch, volume_switch, time_us
// out_ch    out  volume, volume_report, muted, mute_report, backlight_on
// cfg_*     in   step_size, min_volume, max_volume, holdoff_us
//
// An item is registered at the input, then decoded and applied to the state when it advances
// (the output register is empty or being read), which also loads its result into the output register.
// One item is accepted per cycle while the output register drains each cycle.
// A stalled output holds its result; the input register still accepts one item.
// Reset clears the encoder code, volume, attempt time and mute state.
`include "encoder_volume_mute_channel_macros.svh"

module encoder_volume_mute_channel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  evm_in_if.sink                        in_ch,
  evm_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [evm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [evm_pkg::CfgDataW-1:0]  cfg_data_i
);

  evm_pkg::cfg_t cfg;

  evm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic                          in_valid_q;
  logic [evm_pkg::CodeW-1:0]     in_code_q;
  logic                          in_mute_q;
  logic                          in_knob_q;
  logic [evm_pkg::TimeW-1:0]     in_time_q;

  logic                          out_valid_q;
  logic [evm_pkg::VolW-1:0]      out_vol_q;
  logic                          out_vol_rep_q;
  logic                          out_muted_q;
  logic                          out_mute_rep_q;
  logic                          out_light_q;

  logic [evm_pkg::CodeW-1:0]     prev_code_q, prev_code_d;
  logic [evm_pkg::VolW-1:0]      vol_q, vol_d;
  logic [evm_pkg::TimeW-1:0]     last_time_q, last_time_d;
  logic                          muted_q, muted_d;

  logic                          advance;
  logic                          in_take;
  evm_pkg::move_e                move;
  logic                          attempt;
  logic [evm_pkg::LevelW-1:0]    vol_ext;
  logic [evm_pkg::LevelW-1:0]    step_ext;
  logic [evm_pkg::LevelW-1:0]    level;
  logic [evm_pkg::LevelW-1:0]    min_ext;
  logic [evm_pkg::LevelW-1:0]    max_ext;
  logic [evm_pkg::VolW-1:0]      clamped;
  logic [evm_pkg::TimeW-1:0]     elapsed;
  logic                          time_ok;
  logic                          vol_rep;
  logic                          mute_press;

  logic                          out_rep_any;
  logic                          out_vol_fits;
  logic                          out_matches_state;

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    move     = evm_pkg::quad_move(prev_code_q, in_code_q);
    attempt  = (move == evm_pkg::MOVE_CW) || (move == evm_pkg::MOVE_CCW);
    vol_ext  = {2'b00, vol_q};
    step_ext = {3'b000, cfg.step_size};
    min_ext  = {2'b00, cfg.min_volume};
    max_ext  = {2'b00, cfg.max_volume};
    level    = (move == evm_pkg::MOVE_CW) ? (vol_ext + step_ext) : (vol_ext - step_ext);
    if ($signed(level) < $signed(min_ext)) begin
      clamped = cfg.min_volume;
    end else if ($signed(level) > $signed(max_ext)) begin
      clamped = cfg.max_volume;
    end else begin
      clamped = level[evm_pkg::VolW-1:0];
    end
    elapsed    = in_time_q - last_time_q;
    time_ok    = elapsed > {{(evm_pkg::TimeW - evm_pkg::HoldoffW){1'b0}}, cfg.holdoff_us};
    vol_rep    = attempt && time_ok;
    mute_press = !in_mute_q;

    prev_code_d = prev_code_q;
    vol_d       = vol_q;
    last_time_d = last_time_q;
    muted_d     = muted_q;
    if (advance) begin
      prev_code_d = in_code_q;
      if (vol_rep) begin
        vol_d = clamped;
      end
      if (attempt) begin
        last_time_d = in_time_q;
      end
      if (mute_press) begin
        muted_d = !muted_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_code_q <= '0;
      vol_q       <= '0;
      last_time_q <= '0;
      muted_q     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_q <= in_ch.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      prev_code_q <= prev_code_d;
      vol_q       <= vol_d;
      last_time_q <= last_time_d;
      muted_q     <= muted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_code_q <= in_ch.encoder_code;
      in_mute_q <= in_ch.mute_switch;
      in_knob_q <= in_ch.volume_switch;
      in_time_q <= in_ch.time_us;
    end
    if (advance) begin
      out_vol_q      <= vol_d;
      out_vol_rep_q  <= vol_rep;
      out_muted_q    <= muted_d;
      out_mute_rep_q <= mute_press;
      out_light_q    <= vol_rep || mute_press || !in_knob_q;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.volume        = out_vol_q;
  assign out_ch.volume_report = out_vol_rep_q;
  assign out_ch.muted         = out_muted_q;
  assign out_ch.mute_report   = out_mute_rep_q;
  assign out_ch.backlight_on  = out_light_q;

  assign out_rep_any       = out_vol_rep_q || out_mute_rep_q;
  assign out_vol_fits      = (cfg.min_volume > cfg.max_volume) ||
                             ((out_vol_q >= cfg.min_volume) && (out_vol_q <= cfg.max_volume));
  assign out_matches_state = (out_vol_q == vol_q) && (out_muted_q == muted_q);

  `EVM_ASSERT_SAME(a_report_lights, clk_i, rst_ni, out_valid_q && out_rep_any, out_light_q)
  `EVM_ASSERT_SAME(a_vol_in_range, clk_i, rst_ni, out_valid_q && out_vol_rep_q, out_vol_fits)
  `EVM_ASSERT_NEXT(a_state_holds, clk_i, rst_ni, !advance, $stable({vol_q, muted_q, last_time_q}))
  `EVM_ASSERT_NEXT(a_mute_toggles, clk_i, rst_ni, advance && mute_press, muted_q != $past(muted_q))
  `EVM_ASSERT_SAME(a_result_tracks_state, clk_i, rst_ni, out_valid_q, out_matches_state)

endmodule

// ===== tb/tb_encoder_volume_mute_channel.sv =====
module tb_encoder_volume_mute_channel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxIdle       = 17;

  typedef struct packed {
    logic [evm_pkg::VolW-1:0] volume;
    logic                     volume_report;
    logic                     muted;
    logic                     mute_report;
    logic                     backlight_on;
  } knob_report_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [evm_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [evm_pkg::CfgDataW-1:0] cfg_data_i;

  evm_in_if  in_ch ();
  evm_out_if out_ch ();

  encoder_volume_mute_channel dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the channel state and its registers.
  evm_pkg::cfg_t                     knob_cfg;
  logic [evm_pkg::CodeW-1:0]         last_code;
  logic [evm_pkg::VolW-1:0]          level_volume;
  logic signed [evm_pkg::LevelW-1:0] level_pending;
  logic                              level_armed;
  logic [evm_pkg::TimeW-1:0]         attempt_stamp;
  logic                              muted_now;

  knob_report_t volume_mute_reports[$];

  int unsigned error_count      = 0;
  int unsigned items_sent       = 0;
  int unsigned settings_used    = 0;
  int unsigned accepted_changes = 0;
  int unsigned held_off_changes = 0;
  int unsigned mute_toggles     = 0;
  int unsigned rx_stall         = 0;
  int unsigned quiet_cycles     = 0;
  bit          steady           = 1'b0;
  logic [1:0]  knob_pos;
  logic [evm_pkg::TimeW-1:0] stamp;
  int          walk_dir;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [1:0] position_of(input logic [evm_pkg::CodeW-1:0] code);
    return {code[1], code[1] ^ code[0]};
  endfunction

  function automatic logic [evm_pkg::CodeW-1:0] code_at(input logic [1:0] pos);
    return {pos[1], pos[1] ^ pos[0]};
  endfunction

  // Clockwise order of the pins is 00, 01, 11, 10.
  function automatic evm_pkg::move_e step_direction(input logic [evm_pkg::CodeW-1:0] from,
                                                    input logic [evm_pkg::CodeW-1:0] to);
    logic [1:0] delta;
    delta = position_of(to) - position_of(from);
    case (delta)
      2'd0: return evm_pkg::MOVE_NONE;
      2'd1: return evm_pkg::MOVE_CW;
      2'd3: return evm_pkg::MOVE_CCW;
      default: return evm_pkg::MOVE_BAD;
    endcase
  endfunction

  task automatic reset_knob_model();
    knob_cfg.step_size  = evm_pkg::StepReset;
    knob_cfg.min_volume = evm_pkg::MinVolReset;
    knob_cfg.max_volume = evm_pkg::MaxVolReset;
    knob_cfg.holdoff_us = evm_pkg::HoldoffReset;
    last_code     = '0;
    level_volume  = '0;
    level_pending = '0;
    level_armed   = 1'b0;
    attempt_stamp = '0;
    muted_now     = 1'b0;
    knob_pos      = '0;
    stamp         = '0;
    walk_dir      = 1;
  endtask

  task automatic decode_pin_change(input logic [evm_pkg::CodeW-1:0] code,
                                   input logic mute_sw, input logic knob_sw,
                                   input logic [evm_pkg::TimeW-1:0] now);
    evm_pkg::move_e            mv;
    knob_report_t              rep;
    logic [evm_pkg::TimeW-1:0] elapsed;
    int                        v;
    mv = step_direction(last_code, code);
    last_code = code;
    rep = '0;
    if (!level_armed) level_pending = {2'b00, level_volume};
    if (mv == evm_pkg::MOVE_CW) begin
      level_pending = level_pending + {3'b000, knob_cfg.step_size};
      level_armed = 1'b1;
    end else if (mv == evm_pkg::MOVE_CCW) begin
      level_pending = level_pending - {3'b000, knob_cfg.step_size};
      level_armed = 1'b1;
    end
    if (level_armed) begin
      level_armed = 1'b0;
      elapsed = now - attempt_stamp;
      if (elapsed > {8'h00, knob_cfg.holdoff_us}) begin
        v = int'(level_pending);
        if (v < int'(knob_cfg.min_volume)) begin
          v = int'(knob_cfg.min_volume);
        end else if (v > int'(knob_cfg.max_volume)) begin
          v = int'(knob_cfg.max_volume);
        end
        level_volume = v[evm_pkg::VolW-1:0];
        level_pending = {2'b00, level_volume};
        rep.volume_report = 1'b1;
        rep.backlight_on = 1'b1;
        accepted_changes++;
      end else begin
        held_off_changes++;
      end
      attempt_stamp = now;
    end
    if (!mute_sw) begin
      muted_now = !muted_now;
      rep.mute_report = 1'b1;
      rep.backlight_on = 1'b1;
      mute_toggles++;
    end
    if (!knob_sw) rep.backlight_on = 1'b1;
    rep.volume = level_volume;
    rep.muted = muted_now;
    volume_mute_reports.push_back(rep);
  endtask

  task automatic send_event(input logic [evm_pkg::CodeW-1:0] code, input logic mute_sw,
                            input logic knob_sw, input logic [evm_pkg::TimeW-1:0] now);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.encoder_code  <= code;
    in_ch.mute_switch   <= mute_sw;
    in_ch.volume_switch <= knob_sw;
    in_ch.time_us       <= now;
    do @(posedge clk_i); while (!in_ch.ready);
    decode_pin_change(code, mute_sw, knob_sw, now);
    knob_pos = position_of(code);
    stamp = now;
    items_sent++;
  endtask

  task automatic turn(input int dir, input logic [evm_pkg::TimeW-1:0] now,
                      input logic mute_sw, input logic knob_sw);
    send_event(code_at(knob_pos + 2'(dir)), mute_sw, knob_sw, now);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (volume_mute_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input evm_pkg::cfg_idx_e idx,
                           input logic [evm_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      evm_pkg::CFG_STEP_SIZE:  knob_cfg.step_size  = data[evm_pkg::StepW-1:0];
      evm_pkg::CFG_MIN_VOLUME: knob_cfg.min_volume = data[evm_pkg::VolW-1:0];
      evm_pkg::CFG_MAX_VOLUME: knob_cfg.max_volume = data[evm_pkg::VolW-1:0];
      evm_pkg::CFG_HOLDOFF_US: knob_cfg.holdoff_us = data[evm_pkg::HoldoffW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned step, input int unsigned min_vol,
                            input int unsigned max_vol, input int unsigned hold);
    write_reg(evm_pkg::CFG_STEP_SIZE, evm_pkg::CfgDataW'(step));
    write_reg(evm_pkg::CFG_MIN_VOLUME, evm_pkg::CfgDataW'(min_vol));
    write_reg(evm_pkg::CFG_MAX_VOLUME, evm_pkg::CfgDataW'(max_vol));
    write_reg(evm_pkg::CFG_HOLDOFF_US, evm_pkg::CfgDataW'(hold));
    settings_used++;
  endtask

  // Half of the stamps land near the hold-off boundary measured from the last attempt.
  function automatic logic [evm_pkg::TimeW-1:0] pick_stamp();
    logic [evm_pkg::TimeW-1:0] hold;
    hold = {8'h00, knob_cfg.holdoff_us};
    case ($urandom_range(0, 9))
      0, 1, 2: return attempt_stamp + hold + 1 + $urandom_range(0, 2000);
      3:       return attempt_stamp + hold;
      4:       return attempt_stamp + hold + 1;
      5, 6:    return stamp + $urandom_range(0, hold);
      7:       return $urandom;
      default: return stamp + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic random_event();
    int unsigned               pick;
    int                        dir;
    logic                      mute_sw;
    logic                      knob_sw;
    logic [evm_pkg::TimeW-1:0] now;
    pick = $urandom_range(0, 99);
    mute_sw = ($urandom_range(0, 7) != 0);
    knob_sw = ($urandom_range(0, 7) != 0);
    now = pick_stamp();
    if (pick < 85) begin
      if ($urandom_range(0, 3) == 0) walk_dir = -walk_dir;
      dir = ($urandom_range(0, 9) == 0) ? 0 : walk_dir;
      turn(dir, now, mute_sw, knob_sw);
    end else if (pick < 92) begin
      turn(2, now, mute_sw, knob_sw);
    end else begin
      send_event(evm_pkg::CodeW'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end
  endtask

  task automatic random_walk(input int unsigned count);
    repeat (count) random_event();
  endtask

  task automatic test_register_defaults();
    turn(0, 32'd0, 1'b1, 1'b1);
    turn(1, 32'd10001, 1'b1, 1'b1);
    turn(1, 32'd20001, 1'b1, 1'b1);
    turn(1, 32'd30002, 1'b1, 1'b1);
    turn(-1, 32'd40003, 1'b1, 1'b1);
    turn(2, 32'd50004, 1'b1, 1'b1);
    turn(-1, 32'd60005, 1'b1, 1'b1);
    turn(-1, 32'd70006, 1'b1, 1'b1);
    turn(0, 32'd70007, 1'b0, 1'b1);
    turn(0, 32'd70008, 1'b1, 1'b0);
    turn(0, 32'd70009, 1'b0, 1'b0);
  endtask

  task automatic test_field_extremes();
    set_config(100, 0, 255, 0);
    turn(1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    turn(1, 32'h0000_0000, 1'b1, 1'b1);
    turn(1, 32'h0000_0000, 1'b1, 1'b1);
    turn(1, 32'h0000_0005, 1'b1, 1'b1);
    set_config(0, 200, 50, 24'hFF_FFFF);
    turn(1, attempt_stamp + 32'h00FF_FFFF, 1'b1, 1'b1);
    turn(-1, attempt_stamp + 32'h0100_0000, 1'b1, 1'b1);
    set_config(100, 200, 50, 24'hFF_FFFF);
    turn(-1, attempt_stamp + 32'h0100_0000, 1'b1, 1'b1);
    set_config(1, 255, 255, 1);
    turn(-1, attempt_stamp + 32'd2, 1'b0, 1'b0);
  endtask

  task automatic test_random_settings();
    set_config(3, 0, 100, 10000);
    random_walk(180);
    set_config(100, 0, 255, 0);
    random_walk(180);
    set_config(0, 0, 255, 24'hFF_FFFF);
    random_walk(180);
    set_config(7, 200, 50, 500);
    random_walk(180);
    set_config(1, 255, 255, 1);
    random_walk(120);
    set_config(50, 0, 0, 100);
    random_walk(120);
    steady = 1'b1;
    set_config(13, 20, 230, 2000);
    random_walk(180);
    steady = 1'b0;
    repeat (2) begin
      set_config($urandom_range(0, 100), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 50000));
      random_walk(180);
    end
  endtask

  task automatic test_drain_pause();
    set_config(5, 10, 240, 300);
    repeat (6) begin
      random_walk($urandom_range(5, 25));
      wait_drained();
    end
  endtask

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  task automatic check_report();
    knob_report_t want;
    if (volume_mute_reports.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual volume %0d", $time,
               out_ch.volume);
      error_count++;
    end else begin
      want = volume_mute_reports.pop_front();
      compare_field("volume", want.volume, out_ch.volume);
      compare_field("volume_report", want.volume_report, out_ch.volume_report);
      compare_field("muted", want.muted, out_ch.muted);
      compare_field("mute_report", want.mute_report, out_ch.mute_report);
      compare_field("backlight_on", want.backlight_on, out_ch.backlight_on);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_report();
        rx_stall = steady ? 0 : $urandom_range(0, MaxIdle);
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= evm_pkg::CFG_STEP_SIZE;
    cfg_data_i          <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.encoder_code  <= '0;
    in_ch.mute_switch   <= 1'b1;
    in_ch.volume_switch <= 1'b1;
    in_ch.time_us       <= '0;
    reset_knob_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_field_extremes();
    test_random_settings();
    test_drain_pause();
    wait_drained();
    $display("Sent %0d pin-change items over %0d register settings after the defaults.",
             items_sent, settings_used);
    $display("Volume changes accepted %0d, held off %0d; mute toggled %0d times.",
             accepted_changes, held_off_changes, mute_toggles);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
